[rtl/sha1s_pkg.sv]
`default_nettype none
package sha1s_pkg;

  // Action codes on the input channel
  localparam logic [1:0] ACT_ABSORB        = 2'd0;
  localparam logic [1:0] ACT_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] ACT_FINISH        = 2'd2;

  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned ROUNDS       = 80;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_POS_LIMIT = 6'd55;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [DIGEST_WORDS-1:0][31:0] digest_t;

  localparam digest_t SHA1_IV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // Control from the sequencer to the block buffer
  typedef struct packed {
    logic       shift;    // push one byte into the buffer
    logic       step;     // advance the schedule window by one word
    logic [7:0] byte_in;
  } buf_ctrl_t;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic       load;     // working vars <= chaining value
    logic       step;     // one compression round
    logic       fold;     // chaining value += working vars
    logic       restart;  // chaining value <= initial value
    logic [6:0] round;
  } rnd_ctrl_t;

endpackage
`default_nettype wire

[rtl/sha1s_in_if.sv]
`default_nettype none
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface
`default_nettype wire

[rtl/sha1s_out_if.sv]
`default_nettype none
interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface
`default_nettype wire

[rtl/sha1s_msg_buf.sv]
`default_nettype none
module sha1s_msg_buf
  import sha1s_pkg::*;
(
  input  wire logic        clk,
  input  wire buf_ctrl_t   ctl,
  output logic      [31:0] sched_word
);

  // Byte shift line; after 64 pushes entry 0 holds the first byte of the block.
  // During rounds it doubles as the 16-word schedule window.
  logic [7:0] bytes [64];

  logic [31:0] w0, w2, w8, w13, w_new, mix;

  assign w0  = {bytes[0],  bytes[1],  bytes[2],  bytes[3]};
  assign w2  = {bytes[8],  bytes[9],  bytes[10], bytes[11]};
  assign w8  = {bytes[32], bytes[33], bytes[34], bytes[35]};
  assign w13 = {bytes[52], bytes[53], bytes[54], bytes[55]};
  assign mix   = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {mix[30:0], mix[31]};

  assign sched_word = w0;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < 63; i++) bytes[i] <= bytes[i+1];
      bytes[63] <= ctl.byte_in;
    end else if (ctl.step) begin
      for (int i = 0; i < 60; i++) bytes[i] <= bytes[i+4];
      bytes[60] <= w_new[31:24];
      bytes[61] <= w_new[23:16];
      bytes[62] <= w_new[15:8];
      bytes[63] <= w_new[7:0];
    end
  end

endmodule
`default_nettype wire

[rtl/sha1s_round.sv]
`default_nettype none
module sha1s_round
  import sha1s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rnd_ctrl_t   ctl,
  input  wire logic [31:0] sched_word,
  output digest_t          chain
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, t;

  always_comb begin
    if (ctl.round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctl.round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctl.round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + sched_word;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (ctl.step) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      chain <= SHA1_IV;
    end else if (ctl.fold) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

endmodule
`default_nettype wire

[rtl/sha1_stream_hasher.sv]
// SHA-1 over a byte stream.
// Channel msg carries one item per transfer: action 0 absorbs data_byte,
// action 1 absorbs data_byte and then finishes the message, action 2
// finishes without a byte; action 3 is taken and dropped.
// Channel digest returns five transfers per finished message, word_index
// 0 to 4 in big-endian digest order, last_word set on index 4.
// An absorb that does not complete a 64-byte block leaves msg.ready high. One
// that completes a block is followed by load, 80 rounds of the single round
// unit, and the fold into the chaining value. A finish pushes the pad and
// length bytes one per cycle (64 - fill, or 128 - fill when the length does
// not fit), runs one or two compressions, then offers the five words.
// msg.ready is low from the end of an accepted item until its work and its
// digest transfers are done. While the receiver stalls, the current word
// holds on digest and nothing else moves.
// Reset loads the initial chaining value and clears the byte count and bit
// length; the block buffer needs no clearing. After the last digest word the
// same restart happens, so the next message may follow at once.
`default_nettype none
module sha1_stream_hasher
  import sha1s_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sha1s_in_if.sink   msg,
  sha1s_out_if.source digest
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_FOLD  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [6:0]  round;
  logic [2:0]  widx;
  logic        finishing;
  logic        pad_first;
  logic        len_block;

  buf_ctrl_t   buf_ctl;
  rnd_ctrl_t   rnd_ctl;
  logic [31:0] sched_word;
  digest_t     chain;

  logic        in_xfer, out_xfer, absorb;
  logic [7:0]  len_byte, pad_byte;

  assign msg.ready = (state == ST_IDLE);
  assign in_xfer   = msg.valid && msg.ready;
  assign absorb    = in_xfer && (msg.action == ACT_ABSORB || msg.action == ACT_ABSORB_FINISH);

  assign digest.valid = (state == ST_OUT);
  assign out_xfer     = digest.valid && digest.ready;
  assign digest.word_index = widx;
  assign digest.last_word  = (widx == LAST_WORD_IDX);

  always_comb begin
    case (widx)
      3'd0:    digest.digest_word = chain[0];
      3'd1:    digest.digest_word = chain[1];
      3'd2:    digest.digest_word = chain[2];
      3'd3:    digest.digest_word = chain[3];
      default: digest.digest_word = chain[4];
    endcase
  end

  // Length bytes go big-endian into positions 56..63 of the final block
  assign len_byte = 8'(bit_len >> {3'(~fill[2:0]), 3'b000});

  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_BYTE;
    end else if (len_block && fill[5:3] == 3'b111) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    buf_ctl.shift   = absorb || (state == ST_PAD);
    buf_ctl.step    = (state == ST_ROUND);
    buf_ctl.byte_in = (state == ST_PAD) ? pad_byte : msg.data_byte;

    rnd_ctl.load    = (state == ST_LOAD);
    rnd_ctl.step    = (state == ST_ROUND);
    rnd_ctl.fold    = (state == ST_FOLD);
    rnd_ctl.restart = out_xfer && (widx == LAST_WORD_IDX);
    rnd_ctl.round   = round;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bit_len   <= '0;
      round     <= '0;
      widx      <= '0;
      finishing <= 1'b0;
      pad_first <= 1'b0;
      len_block <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (absorb) begin
            fill      <= fill + 6'd1;
            bit_len   <= bit_len + 64'd8;
            finishing <= (msg.action == ACT_ABSORB_FINISH);
            pad_first <= (msg.action == ACT_ABSORB_FINISH);
            len_block <= 1'b0;
            if (fill == LAST_BYTE_POS) begin
              state <= ST_LOAD;
            end else if (msg.action == ACT_ABSORB_FINISH) begin
              state <= ST_PAD;
            end
          end else if (in_xfer && msg.action == ACT_FINISH) begin
            finishing <= 1'b1;
            pad_first <= 1'b1;
            len_block <= 1'b0;
            state     <= ST_PAD;
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          // The length fits in this block only if the pad byte lands at 55 or below
          if (pad_first) len_block <= (fill <= LEN_POS_LIMIT);
          fill <= fill + 6'd1;
          if (fill == LAST_BYTE_POS) state <= ST_LOAD;
        end
        ST_LOAD: begin
          round <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          round <= round + 7'd1;
          if (round == LAST_ROUND) state <= ST_FOLD;
        end
        ST_FOLD: begin
          if (!finishing) begin
            state <= ST_IDLE;
          end else if (len_block) begin
            widx  <= '0;
            state <= ST_OUT;
          end else begin
            // Pad-only block done: the next one carries the length
            if (!pad_first) len_block <= 1'b1;
            state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (out_xfer) begin
            if (widx == LAST_WORD_IDX) begin
              fill      <= '0;
              bit_len   <= '0;
              finishing <= 1'b0;
              len_block <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              widx <= widx + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sha1s_msg_buf u_buf (
    .clk        (clk),
    .ctl        (buf_ctl),
    .sched_word (sched_word)
  );

  sha1s_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rnd_ctl),
    .sched_word (sched_word),
    .chain      (chain)
  );

endmodule
`default_nettype wire
